### rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the sprite compositor
// Sprite entry layout, request kinds and framebuffer geometry defaults.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int SPRITES_DEFAULT      = 12;
    localparam int COLUMN_BYTES_DEFAULT = 4;
    localparam int ROWS_DEFAULT         = 8;

    localparam int SLOT_W    = 4;
    localparam int COORD_W   = 8;
    localparam int PATTERN_W = 28;
    localparam int NIBBLE_W  = 4;
    localparam int PIXEL_W   = 8;
    localparam int INDEX_W   = 5;
    localparam int COL_W     = 2;
    localparam int ROW_W     = 3;

    // last pattern line of a sprite (six lines, 0 to 5)
    localparam logic [COORD_W-1:0] LINE_LAST = 8'd5;
    // offset from the left pixel to the right pixel of a sprite
    localparam logic [COORD_W-1:0] SPAN_END  = 8'd3;

    typedef enum logic
    {
        KIND_WRITE  = 1'b0,
        KIND_RENDER = 1'b1
    } kind_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed
    {
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [PATTERN_W-1:0] pattern;
    } sprite_t;

endpackage

### rtl/spc_sprite_unit.sv
// ----------------------------------------------------------------------------
// spc_sprite_unit: one sprite's contribution to one framebuffer byte
// Matches the sprite against a framebuffer row and column byte and returns
// the pixels it places there, including the part spilling from a split byte.
// ----------------------------------------------------------------------------
module spc_sprite_unit
    import spc_pkg::*;
(
    input  sprite_t            sprite,
    input  logic [ROW_W-1:0]   row,
    input  logic [COL_W-1:0]   col,
    output logic [PIXEL_W-1:0] pixels
);

    logic [COORD_W-1:0] line;
    logic               hit;
    logic [NIBBLE_W-1:0] nibble;
    logic [PIXEL_W-1:0] px;
    logic [COORD_W-1:0] right_x;
    logic [INDEX_W-1:0] first_byte;
    logic [INDEX_W-1:0] second_byte;
    logic [INDEX_W-1:0] col_ext;
    logic [2:0]         spill_shift;
    logic [PIXEL_W-1:0] first_part;
    logic [PIXEL_W-1:0] second_part;

    always_comb
    begin
        line = {{(COORD_W-ROW_W){1'b0}}, row} - sprite.y;
        hit  = (line <= LINE_LAST);
    end

    always_comb
    begin
        case (line[2:0])
            3'd0:    nibble = sprite.pattern[7:4];
            3'd1:    nibble = sprite.pattern[11:8];
            3'd2:    nibble = sprite.pattern[15:12];
            3'd3:    nibble = sprite.pattern[19:16];
            3'd4:    nibble = sprite.pattern[23:20];
            3'd5:    nibble = sprite.pattern[27:24];
            default: nibble = '0;
        endcase
    end

    always_comb
    begin
        px          = {nibble, {(PIXEL_W-NIBBLE_W){1'b0}}};
        right_x     = sprite.x + SPAN_END;
        first_byte  = sprite.x[COORD_W-1:3];
        second_byte = right_x[COORD_W-1:3];
        col_ext     = {{(INDEX_W-COL_W){1'b0}}, col};
        spill_shift = 3'd0 - sprite.x[2:0];
        first_part  = px >> sprite.x[2:0];
        second_part = px << spill_shift;
        pixels      = '0;
        if (hit && (col_ext == first_byte))
        begin
            pixels = pixels | first_part;
        end
        if (hit && (col_ext == second_byte))
        begin
            pixels = pixels | second_part;
        end
    end

endmodule

### rtl/sprite_compositor_led_matrix.sv
// ----------------------------------------------------------------------------
// sprite_compositor_led_matrix: sprite compositor for a one-bit LED matrix
// A write request stores one sprite slot. A render request streams
// ROWS * COLUMN_BYTES framebuffer bytes in ascending order, tlast on the
// final byte. Each byte is built by one shared sprite unit that visits one
// table entry per cycle, holding on the last entry while the output register
// still holds a byte not yet taken. The block takes no new request while
// rendering; writes to a slot at or above SPRITES are dropped. The table is
// cleared at reset.
// ----------------------------------------------------------------------------
module sprite_compositor_led_matrix
    import spc_pkg::*;
#(
    parameter int SPRITES      = SPRITES_DEFAULT,
    parameter int COLUMN_BYTES = COLUMN_BYTES_DEFAULT,
    parameter int ROWS         = ROWS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // slot[3:0], sprite_x[7:0], sprite_y[7:0], pattern[27:0]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // byte_index[4:0], pixels[7:0], zero fill[2:0]
    output logic        m_tlast
);

    localparam int SPR_W = (SPRITES > 1) ? $clog2(SPRITES) : 1;

    state_t state_reg, state_next;

    sprite_t            table_reg [SPRITES];
    logic [SPR_W-1:0]   sprite_idx_reg;
    logic [INDEX_W-1:0] byte_cnt_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [PIXEL_W-1:0] acc_reg;

    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [PIXEL_W-1:0] out_pixels_reg;
    logic               out_last_reg;

    logic               in_acc;
    kind_t              in_kind;
    logic [SLOT_W-1:0]  in_slot;
    sprite_t            in_sprite;
    logic               slot_ok;
    logic               sprite_last;
    logic               out_free;
    logic               frame_last;
    logic               col_last;
    logic               step;
    logic               byte_done;
    logic [PIXEL_W-1:0] contrib;
    logic [PIXEL_W-1:0] byte_value;

    assign in_kind           = kind_t'(s_tuser);
    assign in_slot           = s_tdata[3:0];
    assign in_sprite.x       = s_tdata[11:4];
    assign in_sprite.y       = s_tdata[19:12];
    assign in_sprite.pattern = s_tdata[47:20];
    assign in_acc            = s_tvalid && s_tready;
    assign slot_ok           = ({2'b00, in_slot} < 6'(SPRITES));

    assign sprite_last = (sprite_idx_reg == SPR_W'(SPRITES - 1));
    assign out_free    = !out_valid_reg || m_tready;
    assign frame_last  = (byte_cnt_reg == INDEX_W'(ROWS * COLUMN_BYTES - 1));
    assign col_last    = (col_reg == COL_W'(COLUMN_BYTES - 1));
    assign byte_value  = acc_reg | contrib;

    spc_sprite_unit u_unit
    (
        .sprite (table_reg[sprite_idx_reg]),
        .row    (row_reg),
        .col    (col_reg),
        .pixels (contrib)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_kind == KIND_RENDER))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (byte_done && frame_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        step      = 1'b0;
        byte_done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_RUN:
            begin
                // hold on the last sprite until the output register frees up
                step      = !sprite_last || out_free;
                byte_done = sprite_last && out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sprite_idx_reg <= '0;
            byte_cnt_reg   <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < SPRITES; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (in_acc && (in_kind == KIND_WRITE) && slot_ok)
            begin
                table_reg[SPR_W'(in_slot)] <= in_sprite;
            end

            if (step)
            begin
                sprite_idx_reg <= sprite_last ? '0 : sprite_idx_reg + 1'b1;
            end

            if (byte_done)
            begin
                acc_reg <= '0;
            end
            else if (step)
            begin
                acc_reg <= byte_value;
            end

            if (byte_done)
            begin
                if (frame_last)
                begin
                    byte_cnt_reg <= '0;
                    row_reg      <= '0;
                    col_reg      <= '0;
                end
                else
                begin
                    byte_cnt_reg <= byte_cnt_reg + 1'b1;
                    col_reg      <= col_last ? '0 : col_reg + 1'b1;
                    if (col_last)
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
            end

            if (byte_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (byte_done)
        begin
            out_index_reg  <= byte_cnt_reg;
            out_pixels_reg <= byte_value;
            out_last_reg   <= frame_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_pixels_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

endmodule
